// ----- hdl/ptts_pkg.sv -----
`default_nettype none

package ptts_pkg;

    localparam int COEF_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SEL_BITS  = 3;
    localparam int MAX_ORDER = 4;

    // order_sel codes at or above this pick the order from the coefficients
    localparam logic [SEL_BITS-1:0] SEL_AUTO = SEL_BITS'(5);

    // load enables for the two register ranks of one multiply step
    typedef struct packed {
        logic pp;
        logic sum;
    } ptts_step_en_t;

endpackage

`default_nettype wire

// ----- hdl/ptts_mul_step.sv -----
`default_nettype none

// y = x * d, exact. x is LIMBS words wide and signed, d is one unsigned word.
// Rank 1 holds one word product per limb, rank 2 the recombined sum.
module ptts_mul_step
    import ptts_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int LIMBS     = 1
)
(
    input  wire logic                                  clk,
    input  wire ptts_step_en_t                         en,
    input  wire logic signed [LIMBS*COEF_BITS-1:0]     x,
    input  wire logic        [COEF_BITS-1:0]           d,
    output logic signed      [(LIMBS+1)*COEF_BITS-1:0] y
);

    localparam int W  = COEF_BITS;
    localparam int PW = 2 * W;
    localparam int RW = (LIMBS + 1) * W;

    logic        [PW-1:0] pp_reg  [LIMBS];
    logic        [PW-1:0] pp_next [LIMBS];
    logic        [RW-1:0] even_words;
    logic        [RW-1:0] odd_words;
    logic signed [RW-1:0] y_reg;
    logic signed [RW-1:0] y_next;

    always_comb
    begin
        for (int m = 0; m < LIMBS; m++)
        begin
            if (m == LIMBS - 1)
            begin
                // top limb carries the sign
                pp_next[m] = $signed({{W{x[m*W+W-1]}}, x[m*W +: W]})
                           * $signed({{W{1'b0}}, d});
            end
            else
            begin
                pp_next[m] = {{W{1'b0}}, x[m*W +: W]} * {{W{1'b0}}, d};
            end
        end
    end

    // products of even limbs do not overlap, nor do those of odd limbs
    always_comb
    begin
        even_words = '0;
        odd_words  = '0;
        for (int m = 0; m < LIMBS; m++)
        begin
            if ((m & 1) == 0)
            begin
                even_words[m*W +: PW] = pp_reg[m];
            end
            else
            begin
                odd_words[m*W +: PW] = pp_reg[m];
            end
        end
        y_next = $signed(even_words + odd_words);
    end

    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            pp_reg <= pp_next;
        end
        if (en.sum)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ----- hdl/poly_taylor_time_shift_top.sv -----
// Taylor shift of a quartic trajectory by a time step.
// Input channel (in_valid/in_ready): five signed coefficients coef_0..coef_4,
// the unsigned step elapsed and order_sel (0..4 fixed order, 5..7 automatic).
// Output channel (out_valid/out_ready): new_coef_0..new_coef_4, re-expanded
// around the shifted point and rounded to nearest, plus saturated, which is
// set when any computed coefficient was clipped to the coefficient range.
// Twelve register stages: input, four multiply-by-step levels of two stages
// each, two summing stages and a round/saturate stage that is the output
// register. One transfer per cycle is sustained while the receiver keeps
// out_ready high.
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so empty stages fill up while the receiver stalls.
// in_ready drops only when all twelve stages hold items and out_ready is low.
// Nothing is lost or repeated across a stall.
// Reset (rst_n low) clears all valid bits at once; data registers keep
// whatever they held.
`default_nettype none

module poly_taylor_time_shift_top
    import ptts_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [COEF_BITS-1:0] coef_0,
    input  wire logic signed [COEF_BITS-1:0] coef_1,
    input  wire logic signed [COEF_BITS-1:0] coef_2,
    input  wire logic signed [COEF_BITS-1:0] coef_3,
    input  wire logic signed [COEF_BITS-1:0] coef_4,
    input  wire logic        [COEF_BITS-1:0] elapsed,
    input  wire logic        [SEL_BITS-1:0]  order_sel,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed      [COEF_BITS-1:0] new_coef_0,
    output logic signed      [COEF_BITS-1:0] new_coef_1,
    output logic signed      [COEF_BITS-1:0] new_coef_2,
    output logic signed      [COEF_BITS-1:0] new_coef_3,
    output logic signed      [COEF_BITS-1:0] new_coef_4,
    output logic                             saturated
);

    localparam int W     = COEF_BITS;
    localparam int F     = FRAC_BITS;
    localparam int MX    = (W > F) ? W : F;
    localparam int ACC_W = W + 4 * MX + 5;

    localparam int ST_TERMS   = 2 * MAX_ORDER;
    localparam int ST_DT_LAST = ST_TERMS - 2;
    localparam int ST_SUM_A   = ST_TERMS + 1;
    localparam int ST_SUM_B   = ST_TERMS + 2;
    localparam int ST_OUT     = ST_TERMS + 3;
    localparam int NST        = ST_OUT + 1;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // ---------------- stage control ----------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    always_comb
    begin
        for (int s = 0; s < NST; s++)
        begin
            en[s] = out_ready || !(&(vld_reg | NST'((1 << s) - 1)));
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int s = 1; s < NST; s++)
        begin
            vld_next[s] = en[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ST_OUT];

    // ---------------- order decode ----------------
    logic signed [W-1:0]         cf_in [0:MAX_ORDER];
    logic        [SEL_BITS-1:0]  ord;
    logic        [MAX_ORDER:0]   use_in;

    assign cf_in[0] = coef_0;
    assign cf_in[1] = coef_1;
    assign cf_in[2] = coef_2;
    assign cf_in[3] = coef_3;
    assign cf_in[4] = coef_4;

    always_comb
    begin
        priority if (order_sel < SEL_AUTO)
        begin
            ord = order_sel;
        end
        else if (coef_4 != '0)
        begin
            ord = SEL_BITS'(4);
        end
        else if (coef_3 != '0)
        begin
            ord = SEL_BITS'(3);
        end
        else if (coef_2 != '0)
        begin
            ord = SEL_BITS'(2);
        end
        else
        begin
            ord = SEL_BITS'(1);
        end
        for (int i = 0; i <= MAX_ORDER; i++)
        begin
            use_in[i] = (SEL_BITS'(i) <= ord);
        end
    end

    // ---------------- carried fields ----------------
    logic signed [W-1:0]       cf_reg  [0:ST_SUM_B][0:MAX_ORDER];
    logic        [MAX_ORDER:0] use_reg [0:ST_SUM_B];
    logic        [W-1:0]       dt_reg  [0:ST_DT_LAST];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cf_reg[0]  <= cf_in;
            use_reg[0] <= use_in;
            dt_reg[0]  <= elapsed;
        end
        for (int s = 1; s <= ST_SUM_B; s++)
        begin
            if (en[s])
            begin
                cf_reg[s]  <= cf_reg[s-1];
                use_reg[s] <= use_reg[s-1];
            end
        end
        for (int s = 1; s <= ST_DT_LAST; s++)
        begin
            if (en[s])
            begin
                dt_reg[s] <= dt_reg[s-1];
            end
        end
    end

    // ---------------- products c_i * dt^j ----------------
    ptts_step_en_t step_en [1:MAX_ORDER];

    for (genvar lv = 1; lv <= MAX_ORDER; lv++)
    begin : g_en
        assign step_en[lv] = '{pp: en[2*lv-1], sum: en[2*lv]};
    end

    logic signed [2*W-1:0] y1 [1:4];
    logic signed [3*W-1:0] y2 [2:4];
    logic signed [4*W-1:0] y3 [3:4];
    logic signed [5*W-1:0] y4;

    for (genvar i = 1; i <= 4; i++)
    begin : g_lv1
        ptts_mul_step #(.COEF_BITS(W), .LIMBS(1)) u_mul
        (
            .clk (clk),
            .en  (step_en[1]),
            .x   (cf_reg[0][i]),
            .d   (dt_reg[0]),
            .y   (y1[i])
        );
    end

    for (genvar i = 2; i <= 4; i++)
    begin : g_lv2
        ptts_mul_step #(.COEF_BITS(W), .LIMBS(2)) u_mul
        (
            .clk (clk),
            .en  (step_en[2]),
            .x   (y1[i]),
            .d   (dt_reg[2]),
            .y   (y2[i])
        );
    end

    for (genvar i = 3; i <= 4; i++)
    begin : g_lv3
        ptts_mul_step #(.COEF_BITS(W), .LIMBS(3)) u_mul
        (
            .clk (clk),
            .en  (step_en[3]),
            .x   (y2[i]),
            .d   (dt_reg[4]),
            .y   (y3[i])
        );
    end

    ptts_mul_step #(.COEF_BITS(W), .LIMBS(4)) u_mul_lv4
    (
        .clk (clk),
        .en  (step_en[4]),
        .x   (y3[4]),
        .d   (dt_reg[6]),
        .y   (y4)
    );

    // delay lines that line the shorter products up with c4*dt^4
    logic signed [2*W-1:0] t1_reg [3:ST_TERMS][1:4];
    logic signed [3*W-1:0] t2_reg [5:ST_TERMS][2:4];
    logic signed [4*W-1:0] t3_reg [7:ST_TERMS][3:4];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            t1_reg[3] <= y1;
        end
        for (int s = 4; s <= ST_TERMS; s++)
        begin
            if (en[s])
            begin
                t1_reg[s] <= t1_reg[s-1];
            end
        end
        if (en[5])
        begin
            t2_reg[5] <= y2;
        end
        for (int s = 6; s <= ST_TERMS; s++)
        begin
            if (en[s])
            begin
                t2_reg[s] <= t2_reg[s-1];
            end
        end
        if (en[7])
        begin
            t3_reg[7] <= y3;
        end
        for (int s = 8; s <= ST_TERMS; s++)
        begin
            if (en[s])
            begin
                t3_reg[s] <= t3_reg[s-1];
            end
        end
    end

    // ---------------- term alignment and first sum ----------------
    // term of c_i sits at F*(4-i) above its natural scale for every output
    logic signed [ACC_W-1:0] tm [0:4][0:4];
    logic signed [ACC_W-1:0] pa_next [0:3];
    logic signed [ACC_W-1:0] pb_next [0:3];
    logic signed [ACC_W-1:0] pc_next [0:3];
    logic signed [ACC_W-1:0] pa_reg  [0:3];
    logic signed [ACC_W-1:0] pb_reg  [0:3];
    logic signed [ACC_W-1:0] pc_reg  [0:3];
    logic signed [ACC_W-1:0] sum_reg [0:3];

    always_comb
    begin
        for (int i = 0; i <= MAX_ORDER; i++)
        begin
            for (int j = 0; j <= MAX_ORDER; j++)
            begin
                tm[i][j] = '0;
            end
        end
        for (int i = 0; i <= MAX_ORDER; i++)
        begin
            if (use_reg[ST_TERMS][i])
            begin
                tm[i][0] = ACC_W'(cf_reg[ST_TERMS][i]);
            end
        end
        for (int i = 1; i <= 4; i++)
        begin
            if (use_reg[ST_TERMS][i])
            begin
                tm[i][1] = ACC_W'(t1_reg[ST_TERMS][i]);
            end
        end
        for (int i = 2; i <= 4; i++)
        begin
            if (use_reg[ST_TERMS][i])
            begin
                tm[i][2] = ACC_W'(t2_reg[ST_TERMS][i]);
            end
        end
        for (int i = 3; i <= 4; i++)
        begin
            if (use_reg[ST_TERMS][i])
            begin
                tm[i][3] = ACC_W'(t3_reg[ST_TERMS][i]);
            end
        end
        if (use_reg[ST_TERMS][4])
        begin
            tm[4][4] = ACC_W'(y4);
        end

        // binomial weights 2, 3, 4 and 6 as shifted adds
        pa_next[0] = (tm[0][0] <<< (4*F)) + (tm[1][1] <<< (3*F));
        pb_next[0] = (tm[2][2] <<< (2*F)) + (tm[3][3] <<< F);
        pc_next[0] = tm[4][4];

        pa_next[1] = (tm[1][0] <<< (3*F)) + (tm[2][1] <<< (2*F+1));
        pb_next[1] = (tm[3][2] <<< F) + (tm[3][2] <<< (F+1));
        pc_next[1] = tm[4][3] <<< 2;

        pa_next[2] = tm[2][0] <<< (2*F);
        pb_next[2] = (tm[3][1] <<< F) + (tm[3][1] <<< (F+1));
        pc_next[2] = (tm[4][2] <<< 2) + (tm[4][2] <<< 1);

        pa_next[3] = tm[3][0] <<< F;
        pb_next[3] = tm[4][1] <<< 2;
        pc_next[3] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM_A])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (en[ST_SUM_B])
        begin
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                sum_reg[k] <= pa_reg[k] + pb_reg[k] + pc_reg[k];
            end
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic signed [ACC_W-1:0] rnd [0:3];
    logic signed [ACC_W-1:0] rs  [0:3];
    logic        [3:0]       ovf;
    logic signed [W-1:0]     nc_next [0:MAX_ORDER];
    logic signed [W-1:0]     nc_reg  [0:MAX_ORDER];
    logic                    sat_next;
    logic                    sat_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            rnd[k] = sum_reg[k] + (ACC_W'(1) <<< (F*(MAX_ORDER-k) - 1));
            rs[k]  = rnd[k] >>> (F*(MAX_ORDER-k));
            ovf[k] = !(&rs[k][ACC_W-1:W-1]) && (|rs[k][ACC_W-1:W-1]);
            priority if (!use_reg[ST_SUM_B][k+1])
            begin
                nc_next[k] = cf_reg[ST_SUM_B][k];
            end
            else if (ovf[k])
            begin
                nc_next[k] = rs[k][ACC_W-1] ? MINV : MAXV;
                sat_next   = 1'b1;
            end
            else
            begin
                nc_next[k] = rs[k][W-1:0];
            end
        end
        nc_next[MAX_ORDER] = cf_reg[ST_SUM_B][MAX_ORDER];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            nc_reg  <= nc_next;
            sat_reg <= sat_next;
        end
    end

    assign new_coef_0 = nc_reg[0];
    assign new_coef_1 = nc_reg[1];
    assign new_coef_2 = nc_reg[2];
    assign new_coef_3 = nc_reg[3];
    assign new_coef_4 = nc_reg[4];
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/ptts_checker.sv -----
`default_nettype none

module ptts_checker
    import ptts_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic signed [COEF_BITS-1:0] new_coef_0,
    input wire logic signed [COEF_BITS-1:0] new_coef_1,
    input wire logic signed [COEF_BITS-1:0] new_coef_2,
    input wire logic signed [COEF_BITS-1:0] new_coef_3,
    input wire logic signed [COEF_BITS-1:0] new_coef_4,
    input wire logic                        saturated
);

    localparam logic signed [COEF_BITS-1:0] MAXV = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] MINV = {1'b1, {(COEF_BITS-1){1'b0}}};

    a_reset_empty : assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // an empty or draining output stage lets the whole pipe advance
    a_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked while pipe can advance");

    a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (new_coef_0 == MAXV || new_coef_0 == MINV ||
             new_coef_1 == MAXV || new_coef_1 == MINV ||
             new_coef_2 == MAXV || new_coef_2 == MINV ||
             new_coef_3 == MAXV || new_coef_3 == MINV))
        else $error("saturated flag without a clipped coefficient");

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(new_coef_0) && $stable(new_coef_1) &&
             $stable(new_coef_2) && $stable(new_coef_3) &&
             $stable(new_coef_4) && $stable(saturated)))
        else $error("stalled transfer changed");

endmodule

bind poly_taylor_time_shift_top ptts_checker #(.COEF_BITS(COEF_BITS)) u_ptts_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
    import ptts_pkg::*;

    localparam int CB = COEF_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int WIDE = 256;
    localparam int DRAIN_CYCLES = 24;

    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct packed {
        logic [4:0][CB-1:0]   coef;
        logic [CB-1:0]        dt;
        logic [SEL_BITS-1:0]  sel;
    } shift_req_t;

    typedef struct packed {
        logic [4:0][CB-1:0] coef;
        logic               sat;
    } shift_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CB-1:0] coef_0;
    logic signed [CB-1:0] coef_1;
    logic signed [CB-1:0] coef_2;
    logic signed [CB-1:0] coef_3;
    logic signed [CB-1:0] coef_4;
    logic [CB-1:0]        elapsed;
    logic [SEL_BITS-1:0]  order_sel;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [CB-1:0] new_coef_0;
    logic signed [CB-1:0] new_coef_1;
    logic signed [CB-1:0] new_coef_2;
    logic signed [CB-1:0] new_coef_3;
    logic signed [CB-1:0] new_coef_4;
    logic                 saturated;

    shift_res_t shifted_q[$];
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_len = 0;
    int         hold_seq = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    poly_taylor_time_shift_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coef_0     (coef_0),
        .coef_1     (coef_1),
        .coef_2     (coef_2),
        .coef_3     (coef_3),
        .coef_4     (coef_4),
        .elapsed    (elapsed),
        .order_sel  (order_sel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_coef_0 (new_coef_0),
        .new_coef_1 (new_coef_1),
        .new_coef_2 (new_coef_2),
        .new_coef_3 (new_coef_3),
        .new_coef_4 (new_coef_4),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int choose(int i, int k);
        int r;
        r = 1;
        for (int j = 0; j < k; j++)
        begin
            r = r * (i - j) / (j + 1);
        end
        return r;
    endfunction

    // exact sums in a wide signed accumulator, one rounding per output
    function automatic shift_res_t taylor_shift(shift_req_t req);
        wide_t      cw[5];
        wide_t      dtw;
        wide_t      acc;
        wide_t      term;
        wide_t      bin;
        wide_t      one;
        wide_t      r;
        wide_t      max_v;
        wide_t      min_v;
        int         n;
        int         s;
        shift_res_t res;
        res.coef = req.coef;
        res.sat = 1'b0;
        one = WIDE'(1);
        max_v = '0;
        max_v[CB-2:0] = '1;
        min_v = ~max_v;
        dtw = '0;
        dtw[CB-1:0] = req.dt;
        for (int i = 0; i < 5; i++)
        begin
            cw[i] = {{(WIDE-CB){req.coef[i][CB-1]}}, req.coef[i]};
        end
        if (req.sel >= SEL_AUTO)
        begin
            if (req.coef[4] != '0)
                n = 4;
            else if (req.coef[3] != '0)
                n = 3;
            else if (req.coef[2] != '0)
                n = 2;
            else
                n = 1;
        end
        else
        begin
            n = int'(req.sel);
        end
        for (int k = 0; k < n; k++)
        begin
            acc = '0;
            for (int i = k; i <= n; i++)
            begin
                bin = WIDE'(choose(i, k));
                term = cw[i] * bin;
                for (int j = 0; j < i - k; j++)
                begin
                    term = term * dtw;
                end
                term = term <<< (FB * (n - i));
                acc = acc + term;
            end
            s = FB * (n - k);
            r = (acc + (one <<< (s - 1))) >>> s;
            if (r > max_v)
            begin
                res.coef[k] = max_v[CB-1:0];
                res.sat = 1'b1;
            end
            else if (r < min_v)
            begin
                res.coef[k] = min_v[CB-1:0];
                res.sat = 1'b1;
            end
            else
            begin
                res.coef[k] = r[CB-1:0];
            end
        end
        return res;
    endfunction

    function automatic shift_req_t mk_req(logic [CB-1:0] c0, logic [CB-1:0] c1,
                                          logic [CB-1:0] c2, logic [CB-1:0] c3,
                                          logic [CB-1:0] c4, logic [CB-1:0] dt,
                                          logic [SEL_BITS-1:0] sel);
        shift_req_t req;
        req.coef[0] = c0;
        req.coef[1] = c1;
        req.coef[2] = c2;
        req.coef[3] = c3;
        req.coef[4] = c4;
        req.dt = dt;
        req.sel = sel;
        return req;
    endfunction

    function automatic logic [CB-1:0] rand_coef();
        logic [CB-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = '0;
            2: v = $urandom;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = {1'b0, {(CB-1){1'b1}}};
                    1: v = {1'b1, {(CB-1){1'b0}}};
                    2: v = '1;
                    default: v = 1;
                endcase
            end
            4, 5, 6: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: v = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        endcase
        return v;
    endfunction

    function automatic logic [CB-1:0] rand_dt();
        logic [CB-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = $urandom;
            3, 4, 5, 6: v = $urandom_range(0, 32'h0002_0000);
            default: v = $urandom_range(0, 32'h0000_ffff);
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(shift_req_t req);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        coef_0    <= req.coef[0];
        coef_1    <= req.coef[1];
        coef_2    <= req.coef[2];
        coef_3    <= req.coef[3];
        coef_4    <= req.coef[4];
        elapsed   <= req.dt;
        order_sel <= req.sel;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        shifted_q.push_back(taylor_shift(req));
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (shifted_q.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_directed();
        logic [CB-1:0] cmax;
        logic [CB-1:0] cmin;
        cmax = {1'b0, {(CB-1){1'b1}}};
        cmin = {1'b1, {(CB-1){1'b0}}};
        // order zero passes everything through
        send_item(mk_req(cmax, cmax, cmax, cmax, cmax, '1, SEL_BITS'(0)));
        send_item(mk_req(cmin, cmin, cmin, cmin, cmin, '0, SEL_BITS'(0)));
        // each fixed order on ordinary values, dt = 1.5
        for (int ord = 1; ord <= MAX_ORDER; ord++)
        begin
            send_item(mk_req(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
                             32'h0000_8000, 32'hffff_c000, 32'h0001_8000,
                             SEL_BITS'(ord)));
        end
        send_item(mk_req(32'h1234_5678, 32'h8765_4321, 32'h0bad_cafe,
                         32'hdead_beef, 32'h7fff_0001, '0, SEL_BITS'(MAX_ORDER)));
        // automatic order: highest nonzero among c4, c3, c2, else order one
        send_item(mk_req(32'h0003_0000, 32'h0001_0000, 32'h0002_0000,
                         32'h0001_0000, 32'h0000_0001, 32'h0002_0000, SEL_AUTO));
        send_item(mk_req(32'h0003_0000, 32'h0001_0000, 32'h0002_0000,
                         32'hffff_0000, '0, 32'h0002_0000, SEL_AUTO));
        send_item(mk_req(32'h0003_0000, 32'h0001_0000, 32'h0000_0100,
                         '0, '0, 32'h0002_0000, SEL_AUTO));
        send_item(mk_req(32'h0003_0000, 32'hffff_0000, '0, '0, '0,
                         32'h0002_0000, SEL_AUTO));
        // selectors above auto behave as auto
        send_item(mk_req(32'h0003_0000, 32'h0001_0000, 32'h0002_0000,
                         '0, '0, 32'h0001_8000, SEL_BITS'(SEL_AUTO + 1)));
        send_item(mk_req(32'h0003_0000, 32'h0001_0000, '0, '0, '0,
                         32'h0001_8000, SEL_BITS'(SEL_AUTO + 2)));
        // rounding ties go toward plus infinity
        send_item(mk_req('0, 32'h0000_0001, '0, '0, '0, 32'h0000_8000, SEL_BITS'(1)));
        send_item(mk_req('0, '1, '0, '0, '0, 32'h0000_8000, SEL_BITS'(1)));
        // overflow both ways
        send_item(mk_req(cmax, cmax, '0, '0, '0, '1, SEL_BITS'(1)));
        send_item(mk_req(cmin, cmin, '0, '0, '0, '1, SEL_BITS'(1)));
        send_item(mk_req(cmax, cmax, cmax, cmax, cmax, '1, SEL_BITS'(MAX_ORDER)));
        send_item(mk_req(cmin, cmax, cmin, cmax, cmin, '1, SEL_BITS'(MAX_ORDER)));
        send_item(mk_req(32'h0000_0010, 32'hffff_fff0, 32'h0000_0001, '0, '0,
                         '1, SEL_BITS'(2)));
        wait_drain();
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        shift_req_t req;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            req = mk_req(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_dt(), SEL_BITS'($urandom_range(0, 7)));
            send_item(req);
            if (i == count / 2)
                wait_drain();
        end
        wait_drain();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        shift_req_t req;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 80;
        hold_seq = hold_seq + 1;
        for (int i = 0; i < 40; i++)
        begin
            req = mk_req(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_dt(), SEL_BITS'($urandom_range(0, 7)));
            send_item(req);
        end
        wait_drain();
    endtask

    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        shift_res_t act;
        shift_res_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            act.coef[0] = new_coef_0;
            act.coef[1] = new_coef_1;
            act.coef[2] = new_coef_2;
            act.coef[3] = new_coef_3;
            act.coef[4] = new_coef_4;
            act.sat = saturated;
            if (shifted_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %h", act);
            end
            else
            begin
                exp_res = shifted_q.pop_front();
                for (int k = 0; k < 5; k++)
                begin
                    if (act.coef[k] !== exp_res.coef[k])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("new_coef_%0d mismatch: expected %h actual %h",
                                     k, exp_res.coef[k], act.coef[k]);
                    end
                end
                if (act.sat !== exp_res.sat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("saturated mismatch: expected %b actual %b",
                                 exp_res.sat, act.sat);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        coef_0    = '0;
        coef_1    = '0;
        coef_2    = '0;
        coef_3    = '0;
        coef_4    = '0;
        elapsed   = '0;
        order_sel = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(530, 30, 50);
        test_backpressure();
        test_random(530, 50, 30);
        test_random(530, 0, 0);
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && shifted_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
